@@ rtl/isolated_pixel_check_core_defines.svh @@
// assertion macros for the isolated pixel check core
// expects clk and rst_n in the scope where a macro is used
`ifndef ISOLATED_PIXEL_CHECK_CORE_DEFINES_SVH
`define ISOLATED_PIXEL_CHECK_CORE_DEFINES_SVH

// same-cycle implication
`define IPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ipc_pkg.sv @@
// shared constants, register codes and helper functions for the isolated pixel check
// no dependencies
package ipc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SIZE_W = 11;
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + ((ROW_W > SIZE_W) ? 1 : 1)
                            + ((ROW_W > COL_W && ROW_W > SIZE_W) ? ROW_W - SIZE_W : 0);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1024);

    // zero reads as one, anything above the maximum reads as the maximum
    function automatic logic [CMP_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [CMP_W-1:0]  maxv
    );
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0)
            return CMP_W'(1);
        else if (ext > maxv)
            return maxv;
        else
            return ext;
    endfunction

    // set center pixel with no set orthogonal neighbor
    function automatic logic lonely(
        input logic ctr,
        input logic up,
        input logic dn,
        input logic lf,
        input logic rt
    );
        return ctr & ~up & ~dn & ~lf & ~rt;
    endfunction

endpackage

@@ rtl/isolated_pixel_check_core.sv @@
// isolated pixel check core: line store, window registers and verdict output
// the verdict is registered and valid in the cycle after the frame's last pixel transaction
// throughput: one pixel per cycle while no verdict is held, set by the line store's single read and write port
// the line store is read ahead at the next column into a register, with write forwarding
// reset: rst_n asynchronous, clears counters and flags, sets sizes to their reset values; line store is not cleared
`include "isolated_pixel_check_core_defines.svh"

module isolated_pixel_check_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        pixel_set,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        all_connected,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipc_pkg::DATA_W-1:0]  pwdata,
    output logic [ipc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ipc_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              iso_reg;
    logic              iso_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_data_reg;

    logic              prv_mid_reg;
    logic              prv_up_reg;
    logic              prv_p_reg;
    logic              prv_left_reg;
    logic              prv_pl_reg;

    // bit 1 upper row, bit 0 middle row
    logic [1:0]        line_mem [MAX_WIDTH];
    logic [1:0]        rd_data_reg;
    logic [1:0]        wr_data;

    logic [CMP_W-1:0]  w_eff;
    logic [CMP_W-1:0]  h_eff;
    logic              restart;
    logic [COL_W-1:0]  c_eff;
    logic [ROW_W-1:0]  r_eff;
    logic              iso_base;
    logic              row_ge1;
    logic              row_ge2;
    logic              col_nz;
    logic              last_col;
    logic              last_row;
    logic              frame_end;
    logic              mid_c;
    logic              up_c;
    logic              left_c;
    logic              hit_a;
    logic              hit_b;
    logic              hit_c;
    logic              hit_d;
    logic              iso_now;
    logic              accept;
    logic              cfg_wr;

    assign w_eff = clamp_size(width_reg, CMP_W'(MAX_WIDTH));
    assign h_eff = clamp_size(height_reg, CMP_W'(MAX_HEIGHT));

    // position outside the current size restarts the frame
    assign restart  = (CMP_W'(col_reg) >= w_eff) || (CMP_W'(row_reg) >= h_eff);
    assign c_eff    = restart ? '0 : col_reg;
    assign r_eff    = restart ? '0 : row_reg;
    assign iso_base = restart ? 1'b0 : iso_reg;

    assign row_ge1   = (r_eff != '0);
    assign row_ge2   = (CMP_W'(r_eff) >= CMP_W'(2));
    assign col_nz    = (c_eff != '0);
    assign last_col  = (CMP_W'(c_eff) + CMP_W'(1)) == w_eff;
    assign last_row  = (CMP_W'(r_eff) + CMP_W'(1)) == h_eff;
    assign frame_end = last_col & last_row;

    assign mid_c  = row_ge1 & rd_data_reg[0];
    assign up_c   = row_ge2 & rd_data_reg[1];
    assign left_c = col_nz & prv_mid_reg;

    // previous row, one column behind
    assign hit_a = row_ge1 & col_nz
                 & lonely(prv_mid_reg, prv_up_reg, prv_p_reg, prv_left_reg, mid_c);
    // previous row, right edge
    assign hit_b = row_ge1 & last_col & lonely(mid_c, up_c, pixel_set, left_c, 1'b0);
    // last row, one column behind
    assign hit_c = last_row & col_nz
                 & lonely(prv_p_reg, prv_mid_reg, 1'b0, prv_pl_reg, pixel_set);
    // last row, right edge
    assign hit_d = last_row & last_col
                 & lonely(pixel_set, mid_c, 1'b0, col_nz & prv_p_reg, 1'b0);

    assign iso_now = iso_base | hit_a | hit_b | hit_c | hit_d;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign wr_data  = {mid_c, pixel_set};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        iso_next = iso_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
                iso_next = 1'b0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = ROW_W'(CMP_W'(r_eff) + CMP_W'(1));
                iso_next = iso_now;
            end
            else
            begin
                col_next = COL_W'(CMP_W'(c_eff) + CMP_W'(1));
                row_next = r_eff;
                iso_next = iso_now;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        if (accept && frame_end)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            iso_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            iso_reg       <= iso_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prv_mid_reg  <= mid_c;
            prv_up_reg   <= up_c;
            prv_p_reg    <= pixel_set;
            prv_left_reg <= left_c;
            prv_pl_reg   <= col_nz & prv_p_reg;
        end
        if (accept && frame_end)
            out_data_reg <= ~iso_now;
    end

    // line store: write current column, read next column with forwarding
    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[c_eff] <= wr_data;
        if (accept && (c_eff == col_next))
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= line_mem[col_next];
    end

    assign out_valid     = out_valid_reg;
    assign all_connected = out_data_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    `IPC_ASSERT_NEXT(a_verdict_follows_frame_end, accept && frame_end,
        out_valid_reg && col_reg == '0 && row_reg == '0, "frame end lost verdict or position")
    `IPC_ASSERT_SAME(a_held_verdict_blocks_input, out_valid_reg && !out_ready, !in_ready,
        "input taken while verdict held")
    `IPC_ASSERT_NEXT(a_held_verdict_stable, out_valid_reg && !out_ready,
        out_valid_reg && $stable(all_connected), "verdict changed while held")

endmodule
